### rtl/audio_ring_modulator_assert.svh
`ifndef AUDIO_RING_MODULATOR_ASSERT_SVH
`define AUDIO_RING_MODULATOR_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define ARM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ARM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/arm_pkg.sv
package arm_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned PHASE_W  = 32;
    localparam int unsigned MIX_W    = 16;

    // Configuration register indexes
    localparam logic REG_PHASE_STEP = 1'b0;
    localparam logic REG_MIX_AMOUNT = 1'b1;

    // Unity mix in Q15
    localparam logic [MIX_W-1:0] MIX_ONE = 16'h8000;

    // Sine polynomial coefficients, Q16
    localparam logic [15:0] POLY_C1 = 16'd4640;
    localparam logic [15:0] POLY_C2 = 16'd42047;
    localparam logic [16:0] POLY_C3 = 17'd102944;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_SQ   = 10'b00_0000_0010,
        S_C1   = 10'b00_0000_0100,
        S_U    = 10'b00_0000_1000,
        S_V    = 10'b00_0001_0000,
        S_Y    = 10'b00_0010_0000,
        S_W    = 10'b00_0100_0000,
        S_K    = 10'b00_1000_0000,
        S_ACC  = 10'b01_0000_0000,
        S_FIN  = 10'b10_0000_0000
    } t_state;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MOP_TT,
        MOP_T2C,
        MOP_T2U,
        MOP_TV,
        MOP_MY,
        MOP_KS
    } t_mop;

    typedef struct packed {
        logic load;
        logic advance;
        logic mul_en;
        t_mop mop;
        logic save_t2;
        logic save_y;
        logic save_k;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic bypass;
    } t_dp_status;

endpackage

### rtl/arm_ctrl.sv
module arm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  arm_pkg::t_dp_status i_status,
    output arm_pkg::t_ctrl_cmd  o_cmd
);
    import arm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mop = MOP_TT;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load    = accept;
                o_cmd.advance = accept && !i_status.bypass;
                if (accept) begin
                    n_state = i_status.bypass ? S_FIN : S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_TT;
                n_state      = S_C1;
            end
            S_C1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mop     = MOP_T2C;
                o_cmd.save_t2 = 1'b1;
                n_state       = S_U;
            end
            S_U: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_T2U;
                n_state      = S_V;
            end
            S_V: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_TV;
                n_state      = S_Y;
            end
            S_Y: begin
                o_cmd.save_y = 1'b1;
                n_state      = S_W;
            end
            S_W: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_MY;
                n_state      = S_K;
            end
            S_K: begin
                o_cmd.save_k = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mop    = MOP_KS;
                n_state      = S_FIN;
            end
            S_FIN: begin
                // hold the result until the output register frees up
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/arm_datapath.sv
module arm_datapath #(
    parameter int SINE_ADDR_BITS = 10,
    parameter int CHANNELS       = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  arm_pkg::t_ctrl_cmd                  i_cmd,
    output arm_pkg::t_dp_status                 o_status,
    input  logic [arm_pkg::PHASE_W-1:0]         i_phase_step,
    input  logic [arm_pkg::MIX_W-1:0]           i_mix_amount,
    input  logic                                i_channel,
    input  logic signed [arm_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                i_block_end_in,
    output logic signed [arm_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                o_block_end_out
);
    import arm_pkg::*;

    localparam int T_SHIFT = 18 - SINE_ADDR_BITS;

    logic [PHASE_W-1:0]        r_phase [CHANNELS];
    logic                      ch_sel;
    logic [PHASE_W-1:0]        phase_cur;
    logic [SINE_ADDR_BITS-1:0] addr;
    logic [15:0]               t_base;
    logic [16:0]               t_val;

    logic signed [SAMPLE_W-1:0] r_s;
    logic                       r_blk;
    logic                       r_byp;
    logic [16:0]                r_t;
    logic                       r_neg;
    logic [16:0]                r_t2;
    logic signed [15:0]         r_y;
    logic [32:0]                r_k;
    logic signed [50:0]         r_prod;

    logic signed [32:0]         mul_a;
    logic signed [17:0]         mul_b;
    logic [MIX_W-1:0]           mix_clamp;
    logic [MIX_W-1:0]           mix_inv;
    logic [16:0]                y_mag;
    logic [15:0]                y_sat;
    logic [48:0]                acc_rnd;
    logic signed [18:0]         quo;
    logic signed [SAMPLE_W-1:0] mod_sat;

    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic                       r_block_end_out;

    // Out-of-range channels fall back to accumulator 0
    assign ch_sel = (CHANNELS > 1) ? i_channel : 1'b0;

    always_comb begin
        phase_cur = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (ch_sel == 1'(c)) begin
                phase_cur = r_phase[c];
            end
        end
    end

    // Sine argument: position within the quadrant, mirrored in odd quadrants
    assign addr   = phase_cur[PHASE_W-1 -: SINE_ADDR_BITS];
    assign t_base = {addr[SINE_ADDR_BITS-3:0], {T_SHIFT{1'b0}}};
    assign t_val  = addr[SINE_ADDR_BITS-2] ? (17'h1_0000 - {1'b0, t_base}) : {1'b0, t_base};

    assign mix_clamp = (i_mix_amount > MIX_ONE) ? MIX_ONE : i_mix_amount;
    assign mix_inv   = MIX_ONE - mix_clamp;

    assign o_status.bypass = (i_phase_step == '0) || (i_mix_amount == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_phase[c] <= '0;
            end
        end else if (i_cmd.load && i_cmd.advance) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (ch_sel == 1'(c)) begin
                    r_phase[c] <= r_phase[c] + i_phase_step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s   <= i_sample_in;
            r_blk <= i_block_end_in;
            r_byp <= !i_cmd.advance;
            r_t   <= t_val;
            r_neg <= addr[SINE_ADDR_BITS-1];
        end
    end

    always_comb begin
        unique case (i_cmd.mop)
            MOP_TT: begin
                mul_a = {16'b0, r_t};
                mul_b = {1'b0, r_t};
            end
            MOP_T2C: begin
                mul_a = {16'b0, r_prod[32:16]};
                mul_b = {2'b0, POLY_C1};
            end
            MOP_T2U: begin
                mul_a = {16'b0, r_t2};
                mul_b = {2'b0, POLY_C2 - r_prod[31:16]};
            end
            MOP_TV: begin
                mul_a = {16'b0, r_t};
                mul_b = {1'b0, POLY_C3 - r_prod[32:16]};
            end
            MOP_MY: begin
                mul_a = {17'b0, mix_clamp};
                mul_b = {{2{r_y[15]}}, r_y};
            end
            MOP_KS: begin
                mul_a = r_k;
                mul_b = {{2{r_s[SAMPLE_W-1]}}, r_s};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // Sine sample from t*v: drop 17 fraction bits, clip, apply sign half
    assign y_mag = r_prod[33:17];
    assign y_sat = (y_mag > 17'd32767) ? 16'h7FFF : y_mag[15:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.save_t2) begin
            r_t2 <= r_prod[32:16];
        end
        if (i_cmd.save_y) begin
            r_y <= r_neg ? (16'd0 - y_sat) : y_sat;
        end
        if (i_cmd.save_k) begin
            // dry gain times 2^15 plus wet gain times sine
            r_k <= {2'b0, mix_inv, 15'b0} + r_prod[32:0];
        end
    end

    // Round half up at bit 30, then clip to Q15
    assign acc_rnd = {r_prod[47], r_prod[47:0]} + (49'd1 << 29);
    assign quo     = acc_rnd[48:30];

    always_comb begin
        priority if (quo > 19'sd32767) begin
            mod_sat = 16'sh7FFF;
        end else if (quo < -19'sd32768) begin
            mod_sat = -16'sh8000;
        end else begin
            mod_sat = quo[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_sample_out    <= r_byp ? r_s : mod_sat;
            r_block_end_out <= r_blk;
        end
    end

    assign o_sample_out    = r_sample_out;
    assign o_block_end_out = r_block_end_out;

endmodule

### rtl/audio_ring_modulator.sv
// Ring modulator with dry/wet mix for a two-channel Q15 audio stream.
// Input channel: i_in_valid / o_in_stall carry one item (channel, sample,
// block-end mark). Output channel: o_out_valid / i_out_stall carry the
// modulated sample and the copied block-end mark.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 phase step, 1 mix amount); write only while the block is idle.
// Modulated items run the sine polynomial and the mix as six products
// through one shared 33x18 multiplier, plus two register steps, the
// output load and the accept cycle. With phase step or mix at zero the
// sample passes through, going from accept straight to the output load;
// each item is finished before the next one is taken.
// A new item is taken while an earlier result still sits in the output
// register; if the receiver stalls, the finished item waits in the
// controller until the output register empties, and input is stalled.
// Reset (synchronous, active low) clears both phase accumulators, the
// configuration registers and the output valid.
module audio_ring_modulator #(
    parameter int SINE_ADDR_BITS = 10,
    parameter int CHANNELS       = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [arm_pkg::PHASE_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_channel,
    input  logic signed [arm_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                i_block_end_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [arm_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                o_block_end_out
);
    import arm_pkg::*;

    logic [PHASE_W-1:0] r_phase_step;
    logic [MIX_W-1:0]   r_mix_amount;
    t_ctrl_cmd          cmd;
    t_dp_status         status;
    logic               in_acc;
    logic               out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_mix_amount <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PHASE_STEP: r_phase_step <= i_cfg_data;
                REG_MIX_AMOUNT: r_mix_amount <= i_cfg_data[MIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    arm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    arm_datapath #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .CHANNELS       (CHANNELS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_phase_step    (r_phase_step),
        .i_mix_amount    (r_mix_amount),
        .i_channel       (i_channel),
        .i_sample_in     (i_sample_in),
        .i_block_end_in  (i_block_end_in),
        .o_sample_out    (o_sample_out),
        .o_block_end_out (o_block_end_out)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_take = o_out_valid && !i_out_stall;

`include "audio_ring_modulator_assert.svh"

    `ARM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall, "input not stalled after accept")
    `ARM_ASSERT_NEXT(a_refill_idle, i_clk, i_rst_n, out_take, !o_out_valid || !o_in_stall, "output refilled while busy")
    `ARM_ASSERT_IMP(a_rise_idle, i_clk, i_rst_n, $rose(o_out_valid), !o_in_stall, "result shown while busy")

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SINE_ADDR_BITS = 10;
    localparam int CHANNELS       = 2;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic signed [15:0] sample;
        logic               block_end;
    } t_mod_result;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_cfg_we       = 1'b0;
    logic                     i_cfg_index    = arm_pkg::REG_PHASE_STEP;
    logic [31:0]              i_cfg_data     = '0;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_stall;
    logic                     i_channel      = 1'b0;
    logic signed [15:0]       i_sample_in    = '0;
    logic                     i_block_end_in = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall    = 1'b0;
    logic signed [15:0]       o_sample_out;
    logic                     o_block_end_out;

    // Copy of the block's state and registers
    logic [31:0]              phase_acc [CHANNELS];
    logic [31:0]              phase_step_reg = '0;
    logic [15:0]              mix_reg        = '0;

    t_mod_result              expected_samples [$];
    int                       err_count   = 0;
    int                       idle_cycles = 0;
    logic                     no_idle     = 1'b0;
    int                       hold_req    = 0;
    int                       hold_taken  = 0;
    int                       hold_left   = 0;

    audio_ring_modulator #(
        .SINE_ADDR_BITS(SINE_ADDR_BITS),
        .CHANNELS      (CHANNELS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_channel      (i_channel),
        .i_sample_in    (i_sample_in),
        .i_block_end_in (i_block_end_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_out   (o_sample_out),
        .o_block_end_out(o_block_end_out)
    );

    always #6 i_clk = ~i_clk;

    // Full-wave sine table entry, polynomial evaluated in Q16
    function automatic longint sine_value(input logic [SINE_ADDR_BITS-1:0] addr);
        logic [1:0]        quad;
        longint unsigned   t, t2, u, v, y;
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        t    = 64'(addr[SINE_ADDR_BITS-3:0]) << (18 - SINE_ADDR_BITS);
        if (quad[0])
            t = 65536 - t;
        t2 = (t * t) >> 16;
        u  = 42047 - ((t2 * 4640) >> 16);
        v  = 102944 - ((t2 * u) >> 16);
        y  = ((t * v) >> 16) >> 1;
        if (y > 32767)
            y = 32767;
        return quad[1] ? -longint'(y) : longint'(y);
    endfunction

    function automatic t_mod_result predict_mod(input logic ch, input logic signed [15:0] s,
                                                input logic blk);
        t_mod_result r;
        longint      m, y, acc, q;
        int          idx;
        r.sample    = s;
        r.block_end = blk;
        idx = (int'(ch) < CHANNELS) ? int'(ch) : 0;
        if (phase_step_reg != 0 && mix_reg != 0) begin
            m   = (mix_reg > 16'd32768) ? 64'sd32768 : longint'(mix_reg);
            y   = sine_value(phase_acc[idx][31 -: SINE_ADDR_BITS]);
            acc = longint'(s) * (32768 - m) * 32768 + m * longint'(s) * y;
            // round half up, then saturate
            q   = (acc + 64'sd536870912) >>> 30;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            r.sample = q[15:0];
            phase_acc[idx] = phase_acc[idx] + phase_step_reg;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1 << (32 - SINE_ADDR_BITS);
            3:       return $urandom_range(1, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_mix();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return arm_pkg::MIX_ONE;
            2:       return 16'($urandom_range(32769, 65535));
            3:       return 16'd1;
            default: return 16'($urandom_range(1, 32768));
        endcase
    endfunction

    // Write both registers on consecutive edges; junk in the upper mix bits is ignored
    task automatic set_config(input logic [31:0] step, input logic [15:0] mix);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= arm_pkg::REG_PHASE_STEP;
        i_cfg_data  <= step;
        @(posedge i_clk);
        i_cfg_index <= arm_pkg::REG_MIX_AMOUNT;
        i_cfg_data  <= {16'($urandom), mix};
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        phase_step_reg  = step;
        mix_reg         = mix;
    endtask

    task automatic send_sample(input logic ch, input logic signed [15:0] s, input logic blk);
        while (!no_idle && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_channel      <= ch;
        i_sample_in    <= s;
        i_block_end_in <= blk;
        do
            @(posedge i_clk);
        while (o_in_stall);
        expected_samples.push_back(predict_mod(ch, s, blk));
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_sample(1'($urandom_range(0, 1)), pick_sample(), $urandom_range(0, 7) == 0);
    endtask

    // Drop valid in the step of the last accept, then drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_bypass();
        send_sample(1'b0, 16'sh8000, 1'b1);
        send_sample(1'b1, 16'sh7FFF, 1'b0);
        send_sample(1'b0, 16'sh0000, 1'b0);
        send_sample(1'b1, -16'sd1, 1'b1);
        wait_idle();
        set_config(32'h4000_0000, 16'd0);
        send_sample(1'b0, 16'sh7FFF, 1'b0);
        send_sample(1'b1, 16'sh8000, 1'b1);
        wait_idle();
        set_config(32'd0, arm_pkg::MIX_ONE);
        send_sample(1'b0, 16'sh8000, 1'b0);
        send_sample(1'b1, 16'sd12345, 1'b1);
        wait_idle();
    endtask

    task automatic test_sine_quadrants();
        // quarter-turn steps land on every quadrant edge of the table
        set_config(32'h4000_0000, arm_pkg::MIX_ONE);
        repeat (4) send_sample(1'b0, 16'sh7FFF, 1'b0);
        repeat (4) send_sample(1'b1, 16'sh8000, 1'b1);
        wait_idle();
        set_config(32'hFFFF_FFFF, 16'hFFFF);
        send_sample(1'b0, 16'sh8000, 1'b0);
        send_sample(1'b1, 16'sh7FFF, 1'b0);
        send_sample(1'b0, 16'sh7FFF, 1'b1);
        wait_idle();
        set_config(32'd1 << (32 - SINE_ADDR_BITS), 16'd1);
        send_sample(1'b0, 16'sh8000, 1'b0);
        send_sample(1'b1, 16'sh7FFF, 1'b1);
        send_sample(1'b0, -16'sd1, 1'b0);
        wait_idle();
    endtask

    task automatic test_output_holdoff();
        set_config($urandom | 32'd1, 16'($urandom_range(1, 32768)));
        hold_req <= hold_req + 1;
        send_random(40);
        wait_idle();
    endtask

    task automatic test_input_pause();
        set_config(pick_step() | 32'd1, arm_pkg::MIX_ONE);
        send_random(15);
        wait_idle();
        send_random(15);
        wait_idle();
    endtask

    task automatic test_random_settings(input int phases, input int items);
        for (int p = 0; p < phases; p++) begin
            set_config(pick_step(), pick_mix());
            if (p == phases / 2)
                no_idle <= 1'b1;
            send_random(items);
            wait_idle();
            no_idle <= 1'b0;
        end
    endtask

    initial begin
        for (int c = 0; c < CHANNELS; c++)
            phase_acc[c] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bypass();
        test_sine_quadrants();
        test_output_holdoff();
        test_input_pause();
        test_random_settings(14, 125);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stall, long hold on request, check each accepted item
    always @(posedge i_clk) begin : result_check
        t_mod_result exp_r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected result: sample_out %0d block_end_out %0b",
                           o_sample_out, o_block_end_out);
                    err_count++;
                end else begin
                    exp_r = expected_samples.pop_front();
                    if (o_sample_out !== exp_r.sample) begin
                        $error("sample_out: expected %0d, actual %0d", exp_r.sample, o_sample_out);
                        err_count++;
                    end
                    if (o_block_end_out !== exp_r.block_end) begin
                        $error("block_end_out: expected %0b, actual %0b",
                               exp_r.block_end, o_block_end_out);
                        err_count++;
                    end
                end
            end
            if (hold_taken != hold_req) begin
                hold_taken  <= hold_req;
                hold_left   <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !no_idle && ($urandom_range(0, 99) < 20);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

### filelist.f
+incdir+rtl
rtl/arm_pkg.sv
rtl/arm_ctrl.sv
rtl/arm_datapath.sv
rtl/audio_ring_modulator.sv
sim/tb.sv
